// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the calendar conversion block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Types, constants and the control store of the epoch to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2c_pkg;

  localparam int EPOCH_BITS  = 32;
  localparam int OFFSET_BITS = 16;
  localparam int SUM_BITS    = EPOCH_BITS + 1;
  localparam int DAYS_BITS   = 17;  // whole days of a 33-bit second count
  localparam int OUT_BITS    = 40;  // 38 bits of fields padded to bytes

  // 86400 is 675 shifted left by 7, so the day split divides the upper sum
  // bits by 675 and carries the low 7 bits over into the time of day.
  localparam int DAY_SHIFT  = 7;
  localparam int NUM_BITS   = SUM_BITS - DAY_SHIFT;
  localparam int RECIP_BITS = 27;
  localparam int PROD_BITS  = NUM_BITS + RECIP_BITS;

  localparam logic [9:0]  DAY_ODD       = 10'd675;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400  = 9'd370;

  // Rounded-up reciprocals and their shifts. Each gives the exact quotient
  // for every dividend below 2^26, 86400 and 3600 respectively.
  localparam logic [26:0] RECIP_DAY      = 27'd101806633;
  localparam logic [17:0] RECIP_HOUR     = 18'd149131;
  localparam logic [12:0] RECIP_MIN      = 13'd4370;
  localparam int          RECIP_DAY_SHR  = 36;
  localparam int          RECIP_HOUR_SHR = 29;
  localparam int          RECIP_MIN_SHR  = 18;

  // Micro-operations.
  localparam logic [2:0] OP_ACCEPT = 3'd0;
  localparam logic [2:0] OP_QUO    = 3'd1;
  localparam logic [2:0] OP_REM    = 3'd2;
  localparam logic [2:0] OP_YEAR   = 3'd3;
  localparam logic [2:0] OP_MONTH  = 3'd4;
  localparam logic [2:0] OP_EMIT   = 3'd5;

  // Conditions that let the sequencer move on to the next step.
  localparam logic [2:0] C_ALWAYS = 3'd0;
  localparam logic [2:0] C_IN     = 3'd1;
  localparam logic [2:0] C_YEAR   = 3'd2;
  localparam logic [2:0] C_MONTH  = 3'd3;
  localparam logic [2:0] C_OUT    = 3'd4;

  // Divisor selects.
  localparam logic [1:0] D_DAY  = 2'd0;
  localparam logic [1:0] D_HOUR = 2'd1;
  localparam logic [1:0] D_MIN  = 2'd2;

  // Step addresses.
  localparam logic [3:0] S_IN     = 4'd0;
  localparam logic [3:0] S_DAY_Q  = 4'd1;
  localparam logic [3:0] S_DAY_R  = 4'd2;
  localparam logic [3:0] S_HOUR_Q = 4'd3;
  localparam logic [3:0] S_HOUR_R = 4'd4;
  localparam logic [3:0] S_MIN_Q  = 4'd5;
  localparam logic [3:0] S_MIN_R  = 4'd6;
  localparam logic [3:0] S_YEAR   = 4'd7;
  localparam logic [3:0] S_MONTH  = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] cond;
    logic [1:0] dsel;
    logic [3:0] next;
  } ucode_t;

  // The control program. A step repeats until its condition holds.
  function automatic ucode_t ucode(input logic [3:0] addr);
    ucode_t w;
    unique case (addr)
      S_IN:     w = '{OP_ACCEPT, C_IN,     D_DAY,  S_DAY_Q};
      S_DAY_Q:  w = '{OP_QUO,    C_ALWAYS, D_DAY,  S_DAY_R};
      S_DAY_R:  w = '{OP_REM,    C_ALWAYS, D_DAY,  S_HOUR_Q};
      S_HOUR_Q: w = '{OP_QUO,    C_ALWAYS, D_HOUR, S_HOUR_R};
      S_HOUR_R: w = '{OP_REM,    C_ALWAYS, D_HOUR, S_MIN_Q};
      S_MIN_Q:  w = '{OP_QUO,    C_ALWAYS, D_MIN,  S_MIN_R};
      S_MIN_R:  w = '{OP_REM,    C_ALWAYS, D_MIN,  S_YEAR};
      S_YEAR:   w = '{OP_YEAR,   C_YEAR,   D_DAY,  S_MONTH};
      S_MONTH:  w = '{OP_MONTH,  C_MONTH,  D_DAY,  S_EMIT};
      S_EMIT:   w = '{OP_EMIT,   C_OUT,    D_DAY,  S_IN};
      default:  w = '{OP_ACCEPT, C_ALWAYS, D_DAY,  S_IN};
    endcase
    return w;
  endfunction

  // Days in a month, counted from 0 for January.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1:    n = leap ? 5'd29 : 5'd28;
      4'd3:    n = 5'd30;
      4'd5:    n = 5'd30;
      4'd8:    n = 5'd30;
      4'd10:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/epoch_to_calendar_datetime_core.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_datetime_core
// Converts an epoch second count plus a zone offset into date and time.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   s_*      in         epoch_seconds
//   m_*      out        year, month, day, hour, minute, second
//   cfg_*    in         time_offset (always ready)
//
// An item goes from acceptance to the output register in steps: six multiply steps
// split days, hours and minutes, then one step per year after 1970 and per month
// index (0..11) plus the emit. The next item can be accepted in the cycle after a
// result is loaded. Reset is synchronous and clears the sequencer, the valid flag
// and the offset; a stalled output holds the emit step.
//
`default_nettype none

module epoch_to_calendar_datetime_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream; tdata bits: [31:0] epoch_seconds.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  // Output stream; tdata bits: [11:0] year, [15:12] month, [20:16] day,
  // [25:21] hour, [31:26] minute, [37:32] second, [39:38] zero.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  // Configuration write of time_offset.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  // Sequencer state.
  logic [3:0]  step;

  // Datapath registers.
  logic [e2c_pkg::OFFSET_BITS-1:0] offset;
  logic [e2c_pkg::NUM_BITS-1:0]    num;   // dividend of the current split
  logic [e2c_pkg::DAY_SHIFT-1:0]   lo;    // sum bits below the day divisor's odd part
  logic [e2c_pkg::DAYS_BITS-1:0]   quo;   // quotient of the last multiply step
  logic [e2c_pkg::DAYS_BITS-1:0]   days;
  logic [11:0] year;
  logic [6:0]  ymod100;
  logic [8:0]  ymod400;
  logic [3:0]  month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  e2c_pkg::ucode_t uw;

  logic [e2c_pkg::SUM_BITS-1:0]   sum;
  logic [e2c_pkg::RECIP_BITS-1:0] recip;
  logic [11:0]                    divisor;
  logic [e2c_pkg::PROD_BITS-1:0]  prod;
  logic [e2c_pkg::DAYS_BITS-1:0]  quo_new;
  logic [e2c_pkg::NUM_BITS-1:0]   back;
  logic [e2c_pkg::NUM_BITS-1:0]   rem;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        go;

  assign uw = e2c_pkg::ucode(step);

  assign s_tready  = (step == e2c_pkg::S_IN);
  assign cfg_ready = 1'b1;

  assign sum = {1'b0, s_tdata} + {{(e2c_pkg::SUM_BITS - e2c_pkg::OFFSET_BITS){1'b0}}, offset};

  // Reciprocal and divisor of the current split.
  always_comb begin
    unique case (uw.dsel)
      e2c_pkg::D_DAY: begin
        recip   = e2c_pkg::RECIP_DAY;
        divisor = {2'd0, e2c_pkg::DAY_ODD};
      end
      e2c_pkg::D_HOUR: begin
        recip   = {9'd0, e2c_pkg::RECIP_HOUR};
        divisor = e2c_pkg::SECS_PER_HOUR;
      end
      e2c_pkg::D_MIN: begin
        recip   = {14'd0, e2c_pkg::RECIP_MIN};
        divisor = {6'd0, e2c_pkg::SECS_PER_MIN};
      end
      default: begin
        recip   = e2c_pkg::RECIP_DAY;
        divisor = {2'd0, e2c_pkg::DAY_ODD};
      end
    endcase
  end

  // The quotient step multiplies by the reciprocal and keeps the bits above
  // its shift; the remainder step takes quotient times divisor off again.
  assign prod = {{e2c_pkg::RECIP_BITS{1'b0}}, num} * {{e2c_pkg::NUM_BITS{1'b0}}, recip};

  always_comb begin
    unique case (uw.dsel)
      e2c_pkg::D_DAY:  quo_new = prod[e2c_pkg::RECIP_DAY_SHR +: e2c_pkg::DAYS_BITS];
      e2c_pkg::D_HOUR: quo_new = prod[e2c_pkg::RECIP_HOUR_SHR +: e2c_pkg::DAYS_BITS];
      e2c_pkg::D_MIN:  quo_new = prod[e2c_pkg::RECIP_MIN_SHR +: e2c_pkg::DAYS_BITS];
      default:         quo_new = prod[e2c_pkg::RECIP_DAY_SHR +: e2c_pkg::DAYS_BITS];
    endcase
  end

  assign back = {{(e2c_pkg::NUM_BITS - e2c_pkg::DAYS_BITS){1'b0}}, quo}
              * {{(e2c_pkg::NUM_BITS - 12){1'b0}}, divisor};
  assign rem  = num - back;

  // Gregorian rule from running residues of the year.
  assign leap = (year[1:0] == 2'd0) && ((ymod100 != 7'd0) || (ymod400 == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = e2c_pkg::month_len(month, leap);

  always_comb begin
    unique case (uw.cond)
      e2c_pkg::C_ALWAYS: go = 1'b1;
      e2c_pkg::C_IN:     go = s_tvalid;
      e2c_pkg::C_YEAR:   go = (days < {8'd0, ylen});
      e2c_pkg::C_MONTH:  go = (month == 4'd11) || (days < {12'd0, mlen});
      e2c_pkg::C_OUT:    go = !m_tvalid || m_tready;
      default:           go = 1'b1;
    endcase
  end

  // Sequencer: advance on the step condition.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= e2c_pkg::S_IN;
    end else if (go) begin
      step <= uw.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset <= cfg_data;
    end
  end

  // Datapath driven by the current micro-operation.
  always_ff @(posedge clk) begin
    unique case (uw.op)
      e2c_pkg::OP_ACCEPT: begin
        if (go) begin
          num     <= sum[e2c_pkg::SUM_BITS-1:e2c_pkg::DAY_SHIFT];
          lo      <= sum[e2c_pkg::DAY_SHIFT-1:0];
          year    <= e2c_pkg::EPOCH_YEAR;
          ymod100 <= e2c_pkg::EPOCH_MOD100;
          ymod400 <= e2c_pkg::EPOCH_MOD400;
          month   <= 4'd0;
        end
      end
      e2c_pkg::OP_QUO: begin
        quo <= quo_new;
      end
      e2c_pkg::OP_REM: begin
        unique case (uw.dsel)
          e2c_pkg::D_DAY: begin
            // The time of day is the remainder by 675 with the low bits below it.
            days <= quo;
            num  <= {{(e2c_pkg::NUM_BITS - 10 - e2c_pkg::DAY_SHIFT){1'b0}}, rem[9:0], lo};
          end
          e2c_pkg::D_HOUR: begin
            hour <= quo[4:0];
            num  <= {{(e2c_pkg::NUM_BITS - 12){1'b0}}, rem[11:0]};
          end
          e2c_pkg::D_MIN: begin
            minute <= quo[5:0];
            second <= rem[5:0];
          end
          default: begin
          end
        endcase
      end
      e2c_pkg::OP_YEAR: begin
        if (!go) begin
          days    <= days - {8'd0, ylen};
          year    <= year + 12'd1;
          ymod100 <= (ymod100 == 7'd99) ? 7'd0 : ymod100 + 7'd1;
          ymod400 <= (ymod400 == 9'd399) ? 9'd0 : ymod400 + 9'd1;
        end
      end
      e2c_pkg::OP_MONTH: begin
        if (!go) begin
          days  <= days - {12'd0, mlen};
          month <= month + 4'd1;
        end
      end
      e2c_pkg::OP_EMIT: begin
        if (go) begin
          m_tdata <= {2'b00, second, minute, hour, days[4:0] + 5'd1,
                      month + 4'd1, year};
        end
      end
      default: begin
      end
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((uw.op == e2c_pkg::OP_EMIT) && go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/e2c_chk.sv
// ----------------------------------------------------------------------------
// e2c_chk
// Port-level checks of the epoch to calendar converter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module e2c_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  `CHK_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `CHK_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `CHK_IMPLY(a_date_range, clk, rst, m_tvalid, (m_tdata[11:0] >= 12'd1970) && (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12) && (m_tdata[20:16] >= 5'd1))
  `CHK_IMPLY(a_time_range, clk, rst, m_tvalid, (m_tdata[25:21] < 5'd24) && (m_tdata[31:26] < 6'd60) && (m_tdata[37:32] < 6'd60) && (m_tdata[39:38] == 2'b00))

endmodule

bind epoch_to_calendar_datetime_core e2c_chk u_e2c_chk (.*);

`default_nettype wire

// File: sim/tb_epoch_to_calendar_datetime_core.sv
// ----------------------------------------------------------------------------
// tb_epoch_to_calendar_datetime_core
// Self-checking bench for the epoch to calendar date and time converter.
// Epoch second counts are streamed in under several zone offsets. A local
// calendar model predicts year, month, day, hour, minute and second for every
// accepted item, and each result leaving the block is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_epoch_to_calendar_datetime_core;

  localparam int unsigned SECONDS_PER_DAY  = 86400;
  localparam int unsigned SECONDS_PER_HOUR = 3600;
  localparam int unsigned SECONDS_PER_MIN  = 60;
  localparam int unsigned FIRST_YEAR       = 1970;
  localparam int unsigned LAST_EPOCH_DAY   = 49710;  // last whole day of 32 bits
  localparam int unsigned RANDOM_PHASES    = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 190;
  localparam int unsigned SETTLE_CYCLES    = 200;    // longer than the slowest item takes

  // One result, packed so that it matches bits [37:0] of the output item.
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  // Holds the dates and times still owed by the block, oldest first, and
  // checks every result against the oldest one.
  class calendar_scoreboard;
    calendar_t due_dates[$];
    int unsigned errors;
    int unsigned results_seen;

    function bit is_leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // Full-width sum, whole days and time of day, then the year and month walks.
    function calendar_t convert_epoch(input logic [31:0] ts, input logic [15:0] ofs);
      int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      calendar_t   cal;
      logic [32:0] total;
      int unsigned day_cnt;
      int unsigned tod;
      int unsigned yr;
      int unsigned mon;
      int unsigned span;
      total   = {1'b0, ts} + {17'd0, ofs};
      day_cnt = int'(total / SECONDS_PER_DAY);
      tod     = int'(total % SECONDS_PER_DAY);
      yr      = FIRST_YEAR;
      forever begin
        span = is_leap_year(yr) ? 366 : 365;
        if (day_cnt < span) break;
        day_cnt -= span;
        yr++;
      end
      mon = 0;
      while (mon < 11) begin
        span = month_days[mon];
        if (mon == 1 && is_leap_year(yr)) span = 29;
        if (day_cnt < span) break;
        day_cnt -= span;
        mon++;
      end
      cal.year   = yr[11:0];
      cal.month  = 4'(mon + 1);
      cal.day    = 5'(day_cnt + 1);
      cal.hour   = 5'(tod / SECONDS_PER_HOUR);
      cal.minute = 6'((tod % SECONDS_PER_HOUR) / SECONDS_PER_MIN);
      cal.second = 6'(tod % SECONDS_PER_MIN);
      return cal;
    endfunction

    task flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function int unsigned pending();
      return due_dates.size();
    endfunction

    function void note_epoch(input logic [31:0] ts, input logic [15:0] ofs);
      due_dates.push_back(convert_epoch(ts, ofs));
    endfunction

    task compare_field(input string name, input int unsigned got, input int unsigned want);
      if (got != want)
        flag_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                results_seen, name, got, want));
    endtask

    task check_result(input logic [39:0] word);
      calendar_t got;
      calendar_t want;
      got = word[37:0];
      results_seen++;
      if (due_dates.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with no item in work", results_seen));
        return;
      end
      want = due_dates.pop_front();
      compare_field("year",    got.year,    want.year);
      compare_field("month",   got.month,   want.month);
      compare_field("day",     got.day,     want.day);
      compare_field("hour",    got.hour,    want.hour);
      compare_field("minute",  got.minute,  want.minute);
      compare_field("second",  got.second,  want.second);
      compare_field("padding", word[39:38], 0);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] epoch_seconds
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
                          // [31:26] minute, [37:32] second, [39:38] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;  // time_offset

  calendar_scoreboard sb;
  logic [15:0] zone_offset;  // offset the block holds, as far as the bench knows
  bit          idle_on;      // enables random gaps on both sides

  // Calendar edges with no offset: the first and last second of a day, hour
  // and minute, the leap day of an ordinary leap year and of a century that
  // is one, the missing leap day of 2100, year ends and the 32-bit extremes.
  logic [31:0] plain_cases [20] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd68169600, 32'd68256000, 32'd94694399, 32'd946684799, 32'd951782400,
    32'd951868800, 32'd4107456000, 32'd4107542400, 32'h7FFF_FFFF,
    32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555
  };

  // With the largest offset the first two stop just short of midnight, the next two
  // carry into the next day, month or year, and the last one needs the extra sum bit.
  logic [31:0] carry_cases [6] = '{
    32'd20863, 32'd20864, 32'd946684799, 32'd951782399, 32'hAAAA_AAAA,
    32'hFFFF_FFFF
  };

  epoch_to_calendar_datetime_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Results are taken at the edge where valid and ready were both high
  // before the edge; the model entry for that item was queued long before.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Output back-pressure in random bursts, so that a finished result sometimes
  // waits in the output register while the sender already offers the next item.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Offers one timestamp and holds it until the block takes it. The call
  // must start at a clock edge; valid stays high on return so that back to
  // back items never see it dropped and raised in the same step.
  task automatic push_epoch(input logic [31:0] ts);
    s_tdata  <= ts;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_epoch(ts, zone_offset);
  endtask

  // Random gap on the input side before the next item.
  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stops offering items until every owed result has come out. It waits on the
  // clock before the first check, so that valid is not raised again in the step it was lowered.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Changes the zone offset; only called while the block holds no item.
  task automatic write_offset(input logic [15:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    zone_offset = value;
  endtask

  // Half of the random timestamps are uniform over 32 bits. The rest sit
  // just before a midnight, where any offset may carry into the next day,
  // month or year, or crowd the two ends of the range.
  function automatic logic [31:0] pick_epoch();
    int unsigned sel;
    logic [31:0] midnight;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom();
    if (sel < 8) begin
      midnight = $urandom_range(1, LAST_EPOCH_DAY) * SECONDS_PER_DAY;
      return midnight - $urandom_range(0, 65535);
    end
    if (sel == 8) return $urandom_range(0, 200000);
    return 32'hFFFF_FFFF - $urandom_range(0, 200000);
  endfunction

  initial begin
    logic [15:0] next_offset;
    sb          = new();
    zone_offset = 16'd0;
    idle_on     = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 32'd0;
    cfg_valid <= 1'b0;
    cfg_data  <= 16'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: calendar edges at offset zero, then offset carries at
    // the largest offset, all without gaps.
    write_offset(16'd0);
    foreach (plain_cases[i]) push_epoch(plain_cases[i]);
    drain_results();
    write_offset(16'hFFFF);
    foreach (carry_cases[i]) push_epoch(carry_cases[i]);
    drain_results();

    // Random part. Each phase runs under its own offset; the extremes come
    // first. One phase in the middle and the last one run without any gaps.
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       next_offset = 16'hFFFF;
        1:       next_offset = 16'd0;
        2:       next_offset = 16'd1;
        default: next_offset = 16'($urandom_range(0, 65535));
      endcase
      write_offset(next_offset);
      idle_on = (p != 3) && (p != RANDOM_PHASES - 1);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Once in the run the sender waits in mid-phase for the block to empty.
        if (p == 4 && n == ITEMS_PER_PHASE / 2) drain_results();
        maybe_gap();
        push_epoch(pick_epoch());
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard, several times the slowest correct run.
  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
